[sv/psrs_pkg.sv]
// ----------------------------------------------------------------------------
// psrs_pkg
// Shared types, constants and helpers of the page size range splitter.
// ----------------------------------------------------------------------------
package psrs_pkg;

  localparam int ADDR_BITS_DEFAULT   = 52;
  localparam int MAX_ENTRIES_DEFAULT = 256;

  localparam int FIELD_W  = 52;
  localparam int PAGES_W  = 40;
  localparam int INDEX_W  = 8;
  localparam int NUM_RUNS = 5;

  localparam int SHIFT_4K = 12;
  localparam int SHIFT_2M = 21;
  localparam int SHIFT_1G = 30;

  localparam logic [2:0] RUN_HEAD_4K = 3'd0;
  localparam logic [2:0] RUN_MID_2M  = 3'd1;
  localparam logic [2:0] RUN_BODY_1G = 3'd2;
  localparam logic [2:0] RUN_TAIL_2M = 3'd3;
  localparam logic [2:0] RUN_TAIL_4K = 3'd4;

  typedef enum logic [1:0] {
    SIZE_4K = 2'd0,
    SIZE_2M = 2'd1,
    SIZE_1G = 2'd2
  } size_code_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic size_code_t run_size(input logic [2:0] run);
    size_code_t c;
    case (run)
      RUN_HEAD_4K: c = SIZE_4K;
      RUN_MID_2M:  c = SIZE_2M;
      RUN_BODY_1G: c = SIZE_1G;
      RUN_TAIL_2M: c = SIZE_2M;
      RUN_TAIL_4K: c = SIZE_4K;
      default:     c = SIZE_4K;
    endcase
    return c;
  endfunction

endpackage

[sv/page_size_range_splitter_core.sv]
// ----------------------------------------------------------------------------
// page_size_range_splitter_core
// Splits physical ranges into 4 KiB, 2 MiB and 1 GiB page descriptors.
// ----------------------------------------------------------------------------
// Each accepted range is aligned down to 4 KiB at both ends and cut into up
// to five runs (4 KiB head, 2 MiB up to 1 GiB, 1 GiB body, 2 MiB tail, 4 KiB
// tail); every non-empty run gives one result, merged into the previous
// descriptor where it continues it. A range passes a three stage classifier
// and waits in a two entry queue; the emitter then gives one result per
// cycle while the output is not stalled, one for each run that the range
// produces (one to five), and an empty range is not queued and gives no
// result. A range is accepted every cycle while the queue has room.
module page_size_range_splitter_core import psrs_pkg::*; #(
  parameter int ADDR_BITS   = ADDR_BITS_DEFAULT,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] range_start,
  input  logic [FIELD_W-1:0] range_end,
  input  logic               uncached,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] run_start,
  output logic [PAGES_W-1:0] run_pages,
  output logic [1:0]         size_code,
  output logic               run_uncached,
  output logic               revises_previous,
  output logic [INDEX_W-1:0] entry_index,
  output logic               table_overflow,
  output logic               last_of_run
);

  localparam int QW = 1 + NUM_RUNS + NUM_RUNS * (2 * ADDR_BITS + PAGES_W);

  fifo_status_t  fifo_st;
  logic          push;
  logic          pop;
  logic [QW-1:0] push_data;
  logic [QW-1:0] head_data;

  psrs_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .range_start (range_start),
    .range_end   (range_end),
    .uncached    (uncached),
    .fifo_st     (fifo_st),
    .push        (push),
    .push_data   (push_data)
  );

  psrs_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head_data),
    .status    (fifo_st)
  );

  psrs_back #(
    .ADDR_BITS   (ADDR_BITS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head_data        (head_data),
    .fifo_st          (fifo_st),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .run_start        (run_start),
    .run_pages        (run_pages),
    .size_code        (size_code),
    .run_uncached     (run_uncached),
    .revises_previous (revises_previous),
    .entry_index      (entry_index),
    .table_overflow   (table_overflow),
    .last_of_run      (last_of_run)
  );

endmodule

[sv/psrs_front.sv]
// ----------------------------------------------------------------------------
// psrs_front
// Accepts ranges, aligns them and cuts them into five candidate runs over a
// three stage pipeline, then pushes runs and page counts into the queue.
// ----------------------------------------------------------------------------
module psrs_front import psrs_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FIELD_W-1:0]   range_start,
  input  logic [FIELD_W-1:0]   range_end,
  input  logic                 uncached,
  input  fifo_status_t         fifo_st,
  output logic                 push,
  output logic [1+NUM_RUNS+NUM_RUNS*(2*ADDR_BITS+PAGES_W)-1:0] push_data
);

  localparam int AB = ADDR_BITS;
  localparam int IW = ADDR_BITS + 1;

  localparam logic [IW-1:0] M4K = {{(IW-SHIFT_4K){1'b0}}, {SHIFT_4K{1'b1}}};
  localparam logic [IW-1:0] M2M = {{(IW-SHIFT_2M){1'b0}}, {SHIFT_2M{1'b1}}};
  localparam logic [IW-1:0] M1G = {{(IW-SHIFT_1G){1'b0}}, {SHIFT_1G{1'b1}}};

  function automatic logic [IW-1:0] up2m(input logic [IW-1:0] a);
    return (a + M2M) & ~M2M;
  endfunction

  function automatic logic [IW-1:0] up1g(input logic [IW-1:0] a);
    return (a + M1G) & ~M1G;
  endfunction

  function automatic logic [PAGES_W-1:0] page_count(input logic [AB-1:0] s,
                                                    input logic [AB-1:0] e,
                                                    input size_code_t c);
    logic [AB-1:0] d;
    logic [63:0]   q;
    d = e - s;
    case (c)
      SIZE_1G: q = 64'(d >> SHIFT_1G);
      SIZE_2M: q = 64'(d >> SHIFT_2M);
      default: q = 64'(d >> SHIFT_4K);
    endcase
    return q[PAGES_W-1:0];
  endfunction

  logic          st1_valid;
  logic [IW-1:0] st1_a;
  logic [IW-1:0] st1_l;
  logic          st1_unc;

  logic          st2_valid;
  logic [IW-1:0] st2_s [2];
  logic [IW-1:0] st2_e [2];
  logic [1:0]    st2_v;
  logic [IW-1:0] st2_a;
  logic [IW-1:0] st2_l;
  logic          st2_unc;

  logic                st3_valid;
  logic [AB-1:0]       st3_s [NUM_RUNS];
  logic [AB-1:0]       st3_e [NUM_RUNS];
  logic [NUM_RUNS-1:0] st3_v;
  logic                st3_unc;

  logic adv1, adv2, adv3;
  logic ready1, ready2, ready3;

  logic [63:0]   rs64, re64;
  logic [IW-1:0] in_a, in_l;

  logic [IW-1:0] u2, a1, s1, t1, d2, e1, a2;
  logic          hv, mv;

  logic [IW-1:0] s2, e2, a3, s3, e3, a4;
  logic          gv, tv, fv;

  logic [NUM_RUNS*AB-1:0]      s_flat, e_flat;
  logic [NUM_RUNS*PAGES_W-1:0] p_flat;

  assign adv3   = st3_valid && (!fifo_st.full || st3_v == '0);
  assign ready3 = !st3_valid || adv3;
  assign adv2   = st2_valid && ready3;
  assign ready2 = !st2_valid || adv2;
  assign adv1   = st1_valid && ready2;
  assign ready1 = !st1_valid || adv1;

  assign in_stall = !ready1;
  assign push     = adv3 && st3_v != '0;

  always_comb begin
    rs64 = 64'(range_start);
    re64 = 64'(range_end);
    in_a = {1'b0, rs64[AB-1:0]} & ~M4K;
    in_l = {1'b0, re64[AB-1:0]} & ~M4K;
  end

  always_comb begin
    u2 = up2m(st1_a);
    a1 = (u2 > st1_l) ? st1_l : u2;
    hv = st1_a < a1;
    s1 = up2m(a1);
    t1 = up1g(a1);
    d2 = st1_l & ~M2M;
    e1 = (t1 > d2) ? d2 : t1;
    mv = s1 < e1;
    a2 = mv ? e1 : a1;
  end

  always_comb begin
    s2 = up1g(st2_a);
    e2 = st2_l & ~M1G;
    gv = s2 < e2;
    a3 = gv ? e2 : st2_a;
    s3 = up2m(a3);
    e3 = st2_l & ~M2M;
    tv = s3 < e3;
    a4 = tv ? e3 : a3;
    fv = a4 < st2_l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
    end else begin
      if (ready1) begin
        st1_valid <= in_valid;
      end
      if (ready2) begin
        st2_valid <= adv1;
      end
      if (ready3) begin
        st3_valid <= adv2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready1) begin
      st1_a   <= in_a;
      st1_l   <= in_l;
      st1_unc <= uncached;
    end
    if (adv1) begin
      st2_s[0] <= st1_a;
      st2_e[0] <= a1;
      st2_s[1] <= s1;
      st2_e[1] <= e1;
      st2_v    <= {mv, hv};
      st2_a    <= a2;
      st2_l    <= st1_l;
      st2_unc  <= st1_unc;
    end
    if (adv2) begin
      st3_s[RUN_HEAD_4K] <= st2_s[0][AB-1:0];
      st3_e[RUN_HEAD_4K] <= st2_e[0][AB-1:0];
      st3_s[RUN_MID_2M]  <= st2_s[1][AB-1:0];
      st3_e[RUN_MID_2M]  <= st2_e[1][AB-1:0];
      st3_s[RUN_BODY_1G] <= s2[AB-1:0];
      st3_e[RUN_BODY_1G] <= e2[AB-1:0];
      st3_s[RUN_TAIL_2M] <= s3[AB-1:0];
      st3_e[RUN_TAIL_2M] <= e3[AB-1:0];
      st3_s[RUN_TAIL_4K] <= a4[AB-1:0];
      st3_e[RUN_TAIL_4K] <= st2_l[AB-1:0];
      st3_v              <= {fv, tv, gv, st2_v};
      st3_unc            <= st2_unc;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_RUNS; k++) begin
      s_flat[k*AB +: AB]           = st3_s[k];
      e_flat[k*AB +: AB]           = st3_e[k];
      p_flat[k*PAGES_W +: PAGES_W] = page_count(st3_s[k], st3_e[k], run_size(3'(k)));
    end
    push_data = {st3_unc, st3_v, s_flat, e_flat, p_flat};
  end

endmodule

[sv/psrs_fifo.sv]
// ----------------------------------------------------------------------------
// psrs_fifo
// Two entry queue that decouples the range classifier from the emitter.
// ----------------------------------------------------------------------------
module psrs_fifo import psrs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_status_t     status
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign pop_data     = slots[rd_ptr];
  assign status.full  = count == 2'd2;
  assign status.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/psrs_back.sv]
// ----------------------------------------------------------------------------
// psrs_back
// Walks the queue head's runs one per cycle unless the output stalls, merges
// each into the last descriptor it continues, counts entries, drives results.
// ----------------------------------------------------------------------------
module psrs_back import psrs_pkg::*; #(
  parameter int ADDR_BITS   = ADDR_BITS_DEFAULT,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1+NUM_RUNS+NUM_RUNS*(2*ADDR_BITS+PAGES_W)-1:0] head_data,
  input  fifo_status_t       fifo_st,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] run_start,
  output logic [PAGES_W-1:0] run_pages,
  output logic [1:0]         size_code,
  output logic               run_uncached,
  output logic               revises_previous,
  output logic [INDEX_W-1:0] entry_index,
  output logic               table_overflow,
  output logic               last_of_run
);

  localparam int AB = ADDR_BITS;
  localparam int CW = $clog2(MAX_ENTRIES);
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_ENTRIES - 1);

  logic [AB-1:0]       h_s [NUM_RUNS];
  logic [AB-1:0]       h_e [NUM_RUNS];
  logic [PAGES_W-1:0]  h_p [NUM_RUNS];
  logic [NUM_RUNS-1:0] h_mask;
  logic                h_unc;

  logic [NUM_RUNS-1:0] done;
  logic [NUM_RUNS-1:0] cur;
  logic [NUM_RUNS-1:0] sel_oh;
  logic [2:0]          sel;
  logic                found;
  logic                last;
  logic                emit;
  logic                merge;
  logic                fits;
  size_code_t          code;
  logic [AB-1:0]       sel_s;
  logic [AB-1:0]       sel_e;
  logic [PAGES_W-1:0]  sel_p;
  logic [PAGES_W-1:0]  sum_pages;
  logic [CW-1:0]       idx;
  logic [AB-1:0]       res_start;
  logic [PAGES_W-1:0]  res_pages;
  logic [63:0]         start64;

  logic [AB-1:0]      prev_start;
  logic [AB-1:0]      prev_end;
  logic [PAGES_W-1:0] prev_pages;
  size_code_t         prev_size;
  logic               prev_uncached;
  logic               prev_valid;
  logic [CW-1:0]      entry_count;

  always_comb begin
    for (int k = 0; k < NUM_RUNS; k++) begin
      h_p[k] = head_data[k*PAGES_W +: PAGES_W];
      h_e[k] = head_data[NUM_RUNS*PAGES_W + k*AB +: AB];
      h_s[k] = head_data[NUM_RUNS*(PAGES_W+AB) + k*AB +: AB];
    end
    h_mask = head_data[NUM_RUNS*(PAGES_W+2*AB) +: NUM_RUNS];
    h_unc  = head_data[NUM_RUNS*(PAGES_W+2*AB) + NUM_RUNS];
  end

  always_comb begin
    cur   = h_mask & ~done;
    sel   = 3'd0;
    found = 1'b0;
    for (int k = 0; k < NUM_RUNS; k++) begin
      if (cur[k] && !found) begin
        sel   = 3'(k);
        found = 1'b1;
      end
    end
    sel_oh = NUM_RUNS'(1) << sel;
    last   = (cur & ~sel_oh) == '0;
    emit   = !fifo_st.empty && (!out_valid || !out_stall);
    pop    = emit && last;

    code      = run_size(sel);
    sel_s     = h_s[sel];
    sel_e     = h_e[sel];
    sel_p     = h_p[sel];
    sum_pages = prev_pages + sel_p;
    merge     = prev_valid && prev_size == code && prev_uncached == h_unc &&
                prev_end == sel_s;
    fits      = entry_count < LAST_IDX;

    if (merge) begin
      res_start = prev_start;
      res_pages = sum_pages;
      idx       = entry_count - CW'(1);
    end else if (fits) begin
      res_start = sel_s;
      res_pages = sel_p;
      idx       = entry_count;
    end else begin
      res_start = sel_s;
      res_pages = sel_p;
      idx       = LAST_IDX;
    end
    start64 = 64'(res_start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      done        <= '0;
      prev_valid  <= 1'b0;
      entry_count <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        done <= last ? '0 : (done | sel_oh);
        if (merge) begin
          prev_valid <= 1'b1;
        end else if (fits) begin
          prev_valid  <= 1'b1;
          entry_count <= entry_count + CW'(1);
        end else begin
          prev_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (merge) begin
        prev_pages <= sum_pages;
        prev_end   <= sel_e;
      end else if (fits) begin
        prev_start    <= sel_s;
        prev_end      <= sel_e;
        prev_pages    <= sel_p;
        prev_size     <= code;
        prev_uncached <= h_unc;
      end
      run_start        <= start64[FIELD_W-1:0];
      run_pages        <= res_pages;
      size_code        <= code;
      run_uncached     <= h_unc;
      revises_previous <= merge;
      entry_index      <= INDEX_W'(idx);
      table_overflow   <= !merge && !fits;
      last_of_run      <= last;
    end
  end

`ifndef SYNTHESIS
  a_rev_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(revises_previous && table_overflow))
    else $error("merged descriptor flagged as overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= LAST_IDX)
    else $error("entry count passed the last free table position");

  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    !fifo_st.empty |-> (done & ~h_mask) == '0)
    else $error("emitted run not present in the queue head");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    emit && !merge && fits |=> entry_count == CW'($past(entry_count) + CW'(1)))
    else $error("new descriptor did not advance the entry count");

  a_merge_nonempty: assert property (@(posedge clk) disable iff (rst)
    emit && merge |-> entry_count != '0)
    else $error("merge with no stored descriptor");
`endif

endmodule

[bench/page_size_range_splitter_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_size_range_splitter_core_test
// Self-checking bench for the physical range to page descriptor splitter.
// ----------------------------------------------------------------------------
// Ranges are sent through the input channel while a mirror of the descriptor
// table predicts every descriptor that each range writes or revises. Results
// are checked field by field in order. The stimulus runs from fixed corner
// ranges through chains of adjacent ranges that merge, long output
// back-pressure, drained pauses and random ranges, until the table is full.
// ----------------------------------------------------------------------------
module page_size_range_splitter_core_test;
  import psrs_pkg::*;

  localparam int CAPACITY = MAX_ENTRIES_DEFAULT - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [63:0] COUNT_MASK = (64'd1 << PAGES_W) - 64'd1;

  typedef struct packed {
    logic [FIELD_W-1:0] start;
    logic [PAGES_W-1:0] pages;
    size_code_t         size;
    logic               uncached;
    logic               revises;
    logic [INDEX_W-1:0] index;
    logic               overflow;
    logic               last;
  } descriptor_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] range_start = '0;
  logic [FIELD_W-1:0] range_end = '0;
  logic               uncached = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] run_start;
  logic [PAGES_W-1:0] run_pages;
  logic [1:0]         size_code;
  logic               run_uncached;
  logic               revises_previous;
  logic [INDEX_W-1:0] entry_index;
  logic               table_overflow;
  logic               last_of_run;

  descriptor_t expected_runs[$];

  logic [63:0] tbl_start;
  logic [63:0] tbl_pages;
  size_code_t  tbl_size;
  logic        tbl_uncached;
  bit          tbl_valid;
  int          tbl_count;

  int errors = 0;
  int ranges_sent = 0;
  int empty_ranges = 0;
  int results_seen = 0;
  int merges_seen = 0;
  int overflows_seen = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  page_size_range_splitter_core uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .range_start      (range_start),
    .range_end        (range_end),
    .uncached         (uncached),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .run_start        (run_start),
    .run_pages        (run_pages),
    .size_code        (size_code),
    .run_uncached     (run_uncached),
    .revises_previous (revises_previous),
    .entry_index      (entry_index),
    .table_overflow   (table_overflow),
    .last_of_run      (last_of_run)
  );

  function automatic logic [63:0] round_down(logic [63:0] a, int sh);
    return a & ~((64'd1 << sh) - 64'd1);
  endfunction

  function automatic logic [63:0] round_up(logic [63:0] a, int sh);
    logic [63:0] m;
    m = (64'd1 << sh) - 64'd1;
    return (a + m) & ~m;
  endfunction

  function automatic int page_shift(size_code_t code);
    case (code)
      SIZE_1G: return SHIFT_1G;
      SIZE_2M: return SHIFT_2M;
      default: return SHIFT_4K;
    endcase
  endfunction

  // Writes one run into the table mirror and returns the descriptor it gives.
  function automatic descriptor_t place_run(logic [63:0] s, logic [63:0] e,
                                            size_code_t code, logic unc);
    descriptor_t d;
    int sh;
    logic [63:0] pages;
    sh = page_shift(code);
    pages = (e - s) >> sh;
    d = '0;
    d.size = code;
    d.uncached = unc;
    if (tbl_valid && tbl_size == code && tbl_uncached == unc &&
        tbl_start + (tbl_pages << sh) == s) begin
      tbl_pages = (tbl_pages + pages) & COUNT_MASK;
      d.start = tbl_start[FIELD_W-1:0];
      d.pages = tbl_pages[PAGES_W-1:0];
      d.index = INDEX_W'(tbl_count - 1);
      d.revises = 1'b1;
    end else if (tbl_count < CAPACITY) begin
      tbl_start = s;
      tbl_pages = pages & COUNT_MASK;
      tbl_size = code;
      tbl_uncached = unc;
      tbl_valid = 1'b1;
      d.start = s[FIELD_W-1:0];
      d.pages = tbl_pages[PAGES_W-1:0];
      d.index = INDEX_W'(tbl_count);
      tbl_count++;
    end else begin
      tbl_valid = 1'b0;
      d.start = s[FIELD_W-1:0];
      d.pages = pages[PAGES_W-1:0];
      d.index = INDEX_W'(CAPACITY);
      d.overflow = 1'b1;
    end
    return d;
  endfunction

  task automatic predict_descriptors(logic [FIELD_W-1:0] rs, logic [FIELD_W-1:0] re,
                                     logic unc);
    descriptor_t runs[NUM_RUNS];
    int n;
    logic [63:0] addr;
    logic [63:0] limit;
    logic [63:0] s;
    logic [63:0] e;
    n = 0;
    addr = round_down({{(64-FIELD_W){1'b0}}, rs}, SHIFT_4K);
    limit = round_down({{(64-FIELD_W){1'b0}}, re}, SHIFT_4K);
    s = addr;
    e = round_up(addr, SHIFT_2M);
    if (e > limit) e = limit;
    if (s < e) begin
      runs[n] = place_run(s, e, SIZE_4K, unc);
      n++;
      addr = e;
    end
    s = round_up(addr, SHIFT_2M);
    e = round_up(addr, SHIFT_1G);
    if (e > round_down(limit, SHIFT_2M)) e = round_down(limit, SHIFT_2M);
    if (s < e) begin
      runs[n] = place_run(s, e, SIZE_2M, unc);
      n++;
      addr = e;
    end
    s = round_up(addr, SHIFT_1G);
    e = round_down(limit, SHIFT_1G);
    if (s < e) begin
      runs[n] = place_run(s, e, SIZE_1G, unc);
      n++;
      addr = e;
    end
    s = round_up(addr, SHIFT_2M);
    e = round_down(limit, SHIFT_2M);
    if (s < e) begin
      runs[n] = place_run(s, e, SIZE_2M, unc);
      n++;
      addr = e;
    end
    if (addr < limit) begin
      runs[n] = place_run(addr, limit, SIZE_4K, unc);
      n++;
    end
    if (n == 0) begin
      empty_ranges++;
    end else begin
      runs[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) expected_runs.push_back(runs[i]);
  endtask

  // The valid is left high after a transfer so that a back-to-back range
  // needs only one assignment in the step.
  task automatic send_range(logic [FIELD_W-1:0] rs, logic [FIELD_W-1:0] re, logic unc);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    range_start <= rs;
    range_end <= re;
    uncached <= unc;
    predict_descriptors(rs, re, unc);
    ranges_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_runs.size() != 0);
  endtask

  task automatic draw_range(output logic [FIELD_W-1:0] rs, output logic [FIELD_W-1:0] re);
    logic [63:0] s;
    logic [63:0] len;
    if ($urandom_range(0, 3) == 0) begin
      rs = FIELD_W'({$urandom, $urandom});
      re = FIELD_W'({$urandom, $urandom});
    end else begin
      s = {$urandom, $urandom} & ((64'd1 << $urandom_range(20, FIELD_W)) - 64'd1);
      len = {$urandom, $urandom} & ((64'd1 << $urandom_range(12, 34)) - 64'd1);
      rs = FIELD_W'(s);
      re = FIELD_W'(s + len);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic test_corner_ranges();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_range('0, '0, 1'b0);
    send_range(52'h0_0000_0000_1234, 52'h0_0000_0000_1FFF, 1'b1);
    send_range(52'h0_0000_0010_0000, 52'h0_0000_0000_8000, 1'b0);
    send_range('1, '0, 1'b1);
    send_range(52'h0_0000_0000_0000, 52'h0_0000_0000_1000, 1'b0);
    send_range(52'h0_0000_0000_1FFF, 52'h0_0000_0000_3ABC, 1'b0);
    send_range(52'h0_0000_0000_3000, 52'h0_0000_0000_4000, 1'b1);
    send_range(52'h0_0000_0000_4000, 52'h0_0000_0000_5000, 1'b0);
    send_range(52'h0_0000_0040_0000, 52'h0_0000_0080_0000, 1'b0);
    send_range(52'h0_0000_0080_0000, 52'h0_0000_00C0_0000, 1'b0);
    send_range(52'h0_0001_0000_0000, 52'h0_0002_0000_0000, 1'b1);
    send_range(52'h0_0002_0000_0000, 52'h0_0002_4000_0000, 1'b1);
    send_range(52'h0_0000_0000_1000, 52'h0_0000_8020_1123, 1'b0);
    send_range(52'h0_0000_0000_0000, '1, 1'b1);
    send_range(52'hF_FFFF_FFFF_B000, '1, 1'b0);
    send_range('1, '1, 1'b1);
    send_range(52'hF_FFFF_C000_0000, '1, 1'b1);
    // The 2 MiB tail continues the 2 MiB run of the same range and merges.
    send_range(52'h0_0000_003F_E000, 52'h0_0000_4040_0000, 1'b0);
    pause_sender();
  endtask

  task automatic test_merge_chains(int item_count);
    logic [63:0] base;
    logic [63:0] step;
    int sh;
    int len;
    int done;
    logic unc;
    done = 0;
    while (done < item_count) begin
      case ($urandom_range(0, 2))
        0: sh = SHIFT_4K;
        1: sh = SHIFT_2M;
        default: sh = SHIFT_1G;
      endcase
      unc = 1'($urandom_range(0, 1));
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      base = round_down({$urandom, $urandom} & ((64'd1 << 50) - 64'd1), sh);
      len = $urandom_range(3, 10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          step = {$urandom, $urandom} & ((64'd1 << $urandom_range(sh + 1, 34)) - 64'd1);
          step = round_down(step, SHIFT_4K);
          if (step == 0) step = 64'd1 << SHIFT_4K;
        end else begin
          step = 64'($urandom_range(1, 8)) << sh;
        end
        if ($urandom_range(0, 9) == 0) unc = ~unc;
        if ($urandom_range(0, 11) == 0) base = base + (64'd1 << SHIFT_4K);
        send_range(FIELD_W'(base | 64'($urandom_range(0, 4095))),
                   FIELD_W'((base + step) | 64'($urandom_range(0, 4095))), unc);
        base = base + step;
        done++;
      end
    end
    pause_sender();
  endtask

  // The receiver holds off long enough for the block to fill and stall
  // its input while ranges keep coming back to back.
  task automatic test_output_backpressure();
    logic [FIELD_W-1:0] rs;
    logic [FIELD_W-1:0] re;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_requests++;
    repeat (30) begin
      draw_range(rs, re);
      send_range(rs, re, 1'($urandom_range(0, 1)));
    end
    pause_sender();
  endtask

  task automatic test_drained_pauses();
    logic [FIELD_W-1:0] rs;
    logic [FIELD_W-1:0] re;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (6) begin
      repeat (4) begin
        draw_range(rs, re);
        send_range(rs, re, 1'($urandom_range(0, 1)));
      end
      pause_sender();
    end
  endtask

  task automatic test_random_ranges(int item_count);
    logic [FIELD_W-1:0] rs;
    logic [FIELD_W-1:0] re;
    for (int i = 0; i < item_count; i++) begin
      if (i % 20 == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        recv_idle = $urandom_range(0, 2) != 0;
      end
      draw_range(rs, re);
      send_range(rs, re, 1'($urandom_range(0, 1)));
    end
    pause_sender();
  endtask

  // With the table full, adjacent ranges after an overflow no longer merge.
  task automatic test_full_table();
    logic [FIELD_W-1:0] rs;
    logic [FIELD_W-1:0] re;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    while (tbl_count < CAPACITY) begin
      draw_range(rs, re);
      send_range(rs, re, 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < 30; i++) begin
      if (i % 2 == 0) begin
        draw_range(rs, re);
      end else begin
        rs = re;
        re = rs + FIELD_W'(64'($urandom_range(1, 16)) << SHIFT_4K);
      end
      send_range(rs, re, 1'b0);
    end
    pause_sender();
  endtask

  always @(posedge clk) begin
    descriptor_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (revises_previous) merges_seen++;
        if (table_overflow) overflows_seen++;
        if (expected_runs.size() == 0) begin
          errors++;
          $display("%0t: unexpected descriptor: start %h pages %h size %0d", $time,
                   run_start, run_pages, size_code);
        end else begin
          want = expected_runs.pop_front();
          check_field("run_start", 64'(want.start), 64'(run_start));
          check_field("run_pages", 64'(want.pages), 64'(run_pages));
          check_field("size_code", 64'(want.size), 64'(size_code));
          check_field("run_uncached", 64'(want.uncached), 64'(run_uncached));
          check_field("revises_previous", 64'(want.revises), 64'(revises_previous));
          check_field("entry_index", 64'(want.index), 64'(entry_index));
          check_field("table_overflow", 64'(want.overflow), 64'(table_overflow));
          check_field("last_of_run", 64'(want.last), 64'(last_of_run));
        end
        stall_left = recv_idle ? $urandom_range(0, 6) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d descriptors outstanding", $time,
               WATCHDOG_LIMIT, expected_runs.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tbl_start = '0;
    tbl_pages = '0;
    tbl_size = SIZE_4K;
    tbl_uncached = 1'b0;
    tbl_valid = 1'b0;
    tbl_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_corner_ranges();
    test_merge_chains(280);
    test_output_backpressure();
    test_drained_pauses();
    test_random_ranges(60);
    test_full_table();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_runs.size() != 0) begin
      errors++;
      $display("%0t: %0d expected descriptors never arrived", $time, expected_runs.size());
    end
    $display("Sent %0d ranges (%0d empty) and checked %0d descriptors.", ranges_sent,
             empty_ranges, results_seen);
    $display("Of these %0d revised a merged descriptor and %0d hit the full table.",
             merges_seen, overflows_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[page_size_range_splitter_core.f]
sv/psrs_pkg.sv
sv/psrs_front.sv
sv/psrs_fifo.sv
sv/psrs_back.sv
sv/page_size_range_splitter_core.sv
bench/page_size_range_splitter_core_test.sv
